### rtl/rdps_pkg.sv
// ----------------------------------------------------------------------------
// rdps_pkg
// Shared types and constants for the memory-disk request page splitter.
// ----------------------------------------------------------------------------
package rdps_pkg;

	localparam int BLK_W    = 32;
	localparam int LEN_W    = 17;
	localparam int BUF_W    = 48;
	localparam int DADDR_W  = 52;
	localparam int OFS_W    = 49;
	localparam int BASE_W   = 39;
	localparam int SIZE_W   = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 39;
	localparam int MAX_RESULTS = 33;
	localparam int CNT_W    = $clog2(MAX_RESULTS);

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_PAGES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFINED    = 3'd4;

	localparam logic [LEN_W-1:0] SECTOR_RESET = 17'd512;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_DISK  = 2'd1,
		ST_PAST_END = 2'd2,
		ST_AT_END   = 2'd3
	} status_t;

	typedef struct packed {
		logic [BASE_W-1:0] disk_base_page;
		logic [SIZE_W-1:0] disk_size_pages;
		logic [LEN_W-1:0]  sector_size;
		logic              physical_mode;
		logic              disk_defined;
	} cfg_t;

	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic [LEN_W-1:0]   left_nxt;
		logic [BUF_W-1:0]   buf_nxt;
		logic [DADDR_W-1:0] daddr_nxt;
	} step_t;

	typedef struct packed {
		status_t            status;
		logic               read_not_write;
		logic [DADDR_W-1:0] chunk_disk_address;
		logic [BUF_W-1:0]   chunk_buffer_address;
		logic [LEN_W-1:0]   chunk_length;
		logic [LEN_W-1:0]   trimmed_count;
		logic [LEN_W-1:0]   residual;
		logic               last;
	} desc_t;

endpackage

### rtl/rdps_cfg_if.sv
// ----------------------------------------------------------------------------
// rdps_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface rdps_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rdps_pkg::CFG_IDX_W-1:0]     index;
	logic [rdps_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/rdps_req_if.sv
// ----------------------------------------------------------------------------
// rdps_req_if
// Block request channel: one request per beat.
// ----------------------------------------------------------------------------
interface rdps_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [rdps_pkg::BLK_W-1:0]     block_number;
	logic [rdps_pkg::LEN_W-1:0]     byte_count;
	logic [rdps_pkg::BUF_W-1:0]     buffer_address;

	modport source(output valid, output action, output block_number,
		output byte_count, output buffer_address, input ready);
	modport sink(input valid, input action, input block_number,
		input byte_count, input buffer_address, output ready);
endinterface

### rtl/rdps_desc_if.sv
// ----------------------------------------------------------------------------
// rdps_desc_if
// Transfer descriptor channel: one descriptor per beat.
// ----------------------------------------------------------------------------
interface rdps_desc_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic                           read_not_write;
	logic [rdps_pkg::DADDR_W-1:0]   chunk_disk_address;
	logic [rdps_pkg::BUF_W-1:0]     chunk_buffer_address;
	logic [rdps_pkg::LEN_W-1:0]     chunk_length;
	logic [rdps_pkg::LEN_W-1:0]     trimmed_count;
	logic [rdps_pkg::LEN_W-1:0]     residual;
	logic                           last;

	modport source(output valid, output status, output read_not_write,
		output chunk_disk_address, output chunk_buffer_address,
		output chunk_length, output trimmed_count, output residual,
		output last, input ready);
	modport sink(input valid, input status, input read_not_write,
		input chunk_disk_address, input chunk_buffer_address,
		input chunk_length, input trimmed_count, input residual,
		input last, output ready);
endinterface

### rtl/rdps_cfg_regs.sv
// ----------------------------------------------------------------------------
// rdps_cfg_regs
// Configuration register file; always ready, unknown indexes ignored.
// ----------------------------------------------------------------------------
module rdps_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	rdps_cfg_if.sink       cfg,
	output rdps_pkg::cfg_t regs
);

	rdps_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.disk_base_page  <= '0;
			regs_q.disk_size_pages <= '0;
			regs_q.sector_size     <= rdps_pkg::SECTOR_RESET;
			regs_q.physical_mode   <= 1'b0;
			regs_q.disk_defined    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				rdps_pkg::CFG_BASE_PAGE: begin
					regs_q.disk_base_page <= cfg.data[rdps_pkg::BASE_W-1:0];
				end
				rdps_pkg::CFG_SIZE_PAGES: begin
					regs_q.disk_size_pages <= cfg.data[rdps_pkg::SIZE_W-1:0];
				end
				rdps_pkg::CFG_SECTOR: begin
					regs_q.sector_size <= cfg.data[rdps_pkg::LEN_W-1:0];
				end
				rdps_pkg::CFG_PHYS_MODE: begin
					regs_q.physical_mode <= cfg.data[0];
				end
				rdps_pkg::CFG_DEFINED: begin
					regs_q.disk_defined <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/rdps_step_unit.sv
// ----------------------------------------------------------------------------
// rdps_step_unit
// One split step: chunk length to the nearer page end on either side,
// capped at the bytes left, and the advanced addresses.
// ----------------------------------------------------------------------------
module rdps_step_unit #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic [rdps_pkg::LEN_W-1:0]   left,
	input  logic [rdps_pkg::BUF_W-1:0]   buf_addr,
	input  logic [rdps_pkg::DADDR_W-1:0] daddr,
	output rdps_pkg::step_t              step
);

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam logic [rdps_pkg::LEN_W-1:0] PAGE_LEN = rdps_pkg::LEN_W'(PAGE_BYTES);

	logic [rdps_pkg::LEN_W-1:0] room_b;
	logic [rdps_pkg::LEN_W-1:0] room_d;
	logic [rdps_pkg::LEN_W-1:0] room;

	always_comb begin
		room_b = PAGE_LEN - rdps_pkg::LEN_W'(buf_addr[PAGE_SHIFT-1:0]);
		room_d = PAGE_LEN - rdps_pkg::LEN_W'(daddr[PAGE_SHIFT-1:0]);
		room   = (room_b < room_d) ? room_b : room_d;
		step.len       = (room > left) ? left : room;
		step.left_nxt  = left - step.len;
		step.buf_nxt   = buf_addr + rdps_pkg::BUF_W'(step.len);
		step.daddr_nxt = daddr + rdps_pkg::DADDR_W'(step.len);
	end

endmodule

### rtl/ram_disk_request_page_splitter.sv
// ----------------------------------------------------------------------------
// ram_disk_request_page_splitter
// Turns a memory-disk block request into transfer descriptors.
// ----------------------------------------------------------------------------
// Channels: req takes one block request per beat, desc gives descriptors,
// cfg writes registers (always ready; write only while the block is idle).
// A request runs through a sequencer: block * sector size, the range check
// and trim, and the disk address, each in its own state (S_MUL, S_CHECK,
// S_ADDR), then one descriptor per cycle from the split step unit while
// the output register is free. Errors, end of disk, virtual mode and zero
// length give a single descriptor. With 4 KiB pages and 64 KiB requests
// an item reaches 33 descriptors. req.ready is high only when the
// sequencer is idle; the next request is taken while the last descriptor
// still waits in the output register.
// If desc.ready is low the output register holds and the sequencer waits
// in S_EMIT. Reset clears the sequencer and output valid and sets
// registers to their defaults (sector size 512, disk undefined).
// PAGE_BYTES must be a power of two; the block does not enforce it.
// ----------------------------------------------------------------------------
module ram_disk_request_page_splitter #(
	parameter int PAGE_BYTES   = 4096,
	parameter int MAX_TRANSFER = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	rdps_cfg_if.sink    cfg,
	rdps_req_if.sink    req,
	rdps_desc_if.source desc
);

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam logic [rdps_pkg::LEN_W-1:0] MAX_LEN = rdps_pkg::LEN_W'(MAX_TRANSFER);
	localparam logic [rdps_pkg::CNT_W-1:0] LAST_IDX =
		rdps_pkg::CNT_W'(rdps_pkg::MAX_RESULTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CHECK,
		S_ADDR,
		S_EMIT
	} state_t;

	rdps_pkg::cfg_t  regs;
	rdps_pkg::step_t step;

	state_t                        state_q;
	logic                          rnw_q;
	logic [rdps_pkg::BLK_W-1:0]    blk_q;
	logic [rdps_pkg::LEN_W-1:0]    count_q;
	logic [rdps_pkg::OFS_W-1:0]    offset_q;
	rdps_pkg::status_t             status_q;
	logic [rdps_pkg::LEN_W-1:0]    trim_q;
	logic [rdps_pkg::LEN_W-1:0]    left_q;
	logic [rdps_pkg::BUF_W-1:0]    buf_q;
	logic [rdps_pkg::DADDR_W-1:0]  daddr_q;
	logic [rdps_pkg::CNT_W-1:0]    n_q;
	logic                          single_q;
	logic                          out_valid_q;
	rdps_pkg::desc_t               out_q;

	logic [rdps_pkg::LEN_W-1:0]    count_sat;
	logic [rdps_pkg::OFS_W-1:0]    product;
	logic [rdps_pkg::OFS_W-1:0]    disk_bytes;
	logic [rdps_pkg::OFS_W-1:0]    room_left;
	logic [rdps_pkg::DADDR_W-1:0]  base_bytes;
	logic                          out_free;
	logic                          fin;

	rdps_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rdps_step_unit #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_step_unit (
		.left     (left_q),
		.buf_addr (buf_q),
		.daddr    (daddr_q),
		.step     (step)
	);

	assign count_sat  = (req.byte_count > MAX_LEN) ? MAX_LEN : req.byte_count;
	assign product    = rdps_pkg::OFS_W'(blk_q) * rdps_pkg::OFS_W'(regs.sector_size);
	assign disk_bytes = rdps_pkg::OFS_W'(regs.disk_size_pages) << PAGE_SHIFT;
	assign room_left  = disk_bytes - offset_q;
	assign base_bytes = rdps_pkg::DADDR_W'(regs.disk_base_page) << PAGE_SHIFT;
	assign out_free   = !out_valid_q || desc.ready;
	assign fin        = (step.left_nxt == '0) || (n_q == LAST_IDX);

	assign req.ready                 = (state_q == S_IDLE);
	assign desc.valid                = out_valid_q;
	assign desc.status               = out_q.status;
	assign desc.read_not_write       = out_q.read_not_write;
	assign desc.chunk_disk_address   = out_q.chunk_disk_address;
	assign desc.chunk_buffer_address = out_q.chunk_buffer_address;
	assign desc.chunk_length         = out_q.chunk_length;
	assign desc.trimmed_count        = out_q.trimmed_count;
	assign desc.residual             = out_q.residual;
	assign desc.last                 = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (desc.ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						rnw_q   <= req.action;
						blk_q   <= req.block_number;
						count_q <= count_sat;
						buf_q   <= req.buffer_address;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					offset_q <= product;
					state_q  <= S_CHECK;
				end
				S_CHECK: begin
					trim_q <= count_q;
					if (!regs.disk_defined) begin
						status_q <= rdps_pkg::ST_NO_DISK;
					end else if (offset_q > disk_bytes) begin
						status_q <= rdps_pkg::ST_PAST_END;
					end else if (offset_q == disk_bytes) begin
						status_q <= rdps_pkg::ST_AT_END;
					end else begin
						status_q <= rdps_pkg::ST_OK;
						if (rdps_pkg::OFS_W'(count_q) > room_left) begin
							trim_q <= room_left[rdps_pkg::LEN_W-1:0];
						end
					end
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					n_q <= '0;
					if (status_q == rdps_pkg::ST_OK) begin
						daddr_q  <= base_bytes + rdps_pkg::DADDR_W'(offset_q);
						left_q   <= trim_q;
						single_q <= !regs.physical_mode || (trim_q == '0);
					end else begin
						daddr_q  <= '0;
						buf_q    <= '0;
						single_q <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q                <= 1'b1;
						out_q.status               <= status_q;
						out_q.read_not_write       <= rnw_q;
						out_q.chunk_disk_address   <= daddr_q;
						out_q.chunk_buffer_address <= buf_q;
						out_q.trimmed_count        <= trim_q;
						if (single_q) begin
							out_q.last <= 1'b1;
							if (status_q == rdps_pkg::ST_OK) begin
								out_q.chunk_length <= trim_q;
								out_q.residual     <= '0;
							end else begin
								out_q.chunk_length <= '0;
								out_q.residual     <= trim_q;
							end
							state_q <= S_IDLE;
						end else begin
							out_q.chunk_length <= step.len;
							out_q.residual     <= '0;
							out_q.last         <= fin;
							left_q             <= step.left_nxt;
							buf_q              <= step.buf_nxt;
							daddr_q            <= step.daddr_nxt;
							n_q                <= n_q + rdps_pkg::CNT_W'(1);
							if (fin) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
